### rtl/schwarzschild_orbit_euler_step_defines.svh
// Assertion macros for the checker file.
// No dependencies.
`ifndef SCHWARZSCHILD_ORBIT_EULER_STEP_DEFINES_SVH
`define SCHWARZSCHILD_ORBIT_EULER_STEP_DEFINES_SVH

// checked only outside reset
`define SOSE_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("sose assertion failed");

// checked on every edge, reset included
`define SOSE_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("sose assertion failed");

`endif

### rtl/sose_pkg.sv
// Shared types, constants and the step program of the orbit integrator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sose_pkg;

   localparam int W = 64;
   localparam logic [W-1:0] Q_ONE = 64'h0000_0001_0000_0000;
   localparam int PROG_LEN = 40;
   localparam int PC_W = 6;
   // program step after which the metric factor is known
   localparam logic [PC_W-1:0] PC_F_CHECK = 6'd6;
   localparam logic [PC_W-1:0] PC_LAST = 6'(PROG_LEN - 1);

   typedef enum logic [1:0] {
      CSR_GM  = 2'd0,
      CSR_ICC = 2'd1,
      CSR_DT  = 2'd2,
      CSR_NONE = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      OP_MUL, OP_DIV, OP_ADD, OP_NEG
   } op_type;

   typedef enum logic [4:0] {
      SEL_T, SEL_R, SEL_P, SEL_TD, SEL_RD, SEL_PD,
      SEL_GM, SEL_ICC, SEL_DT, SEL_ONE,
      SEL_U, SEL_G, SEL_H, SEL_S, SEL_F, SEL_HF,
      SEL_AT, SEL_AR, SEL_AP, SEL_A, SEL_B
   } sel_type;

   typedef struct packed {
      op_type  op;
      sel_type src_a;
      sel_type src_b;
      sel_type dst;
   } instr_type;

   typedef struct packed {
      logic      start;
      logic      load;
      logic      capture;
      instr_type instr;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic res_zero;
      logic r_zero;
   } stat_type;

   function automatic instr_type mk(op_type op, sel_type a, sel_type b, sel_type d);
      instr_type i;
      i.op = op;
      i.src_a = a;
      i.src_b = b;
      i.dst = d;
      return i;
   endfunction

   // one Euler step as a sequence of operations on the register file
   function automatic instr_type program_step(logic [PC_W-1:0] pc);
      instr_type i;
      unique case (pc)
         6'd0:  i = mk(OP_DIV, SEL_GM,  SEL_R,   SEL_U);
         6'd1:  i = mk(OP_DIV, SEL_U,   SEL_R,   SEL_G);
         6'd2:  i = mk(OP_MUL, SEL_G,   SEL_ICC, SEL_H);
         6'd3:  i = mk(OP_MUL, SEL_U,   SEL_ICC, SEL_S);
         6'd4:  i = mk(OP_ADD, SEL_S,   SEL_S,   SEL_A);
         6'd5:  i = mk(OP_NEG, SEL_A,   SEL_A,   SEL_A);
         6'd6:  i = mk(OP_ADD, SEL_ONE, SEL_A,   SEL_F);
         6'd7:  i = mk(OP_DIV, SEL_ONE, SEL_F,   SEL_A);
         6'd8:  i = mk(OP_MUL, SEL_H,   SEL_A,   SEL_HF);
         6'd9:  i = mk(OP_MUL, SEL_TD,  SEL_RD,  SEL_A);
         6'd10: i = mk(OP_MUL, SEL_HF,  SEL_A,   SEL_A);
         6'd11: i = mk(OP_ADD, SEL_A,   SEL_A,   SEL_A);
         6'd12: i = mk(OP_NEG, SEL_A,   SEL_A,   SEL_AT);
         6'd13: i = mk(OP_MUL, SEL_G,   SEL_F,   SEL_A);
         6'd14: i = mk(OP_MUL, SEL_TD,  SEL_TD,  SEL_B);
         6'd15: i = mk(OP_MUL, SEL_A,   SEL_B,   SEL_A);
         6'd16: i = mk(OP_NEG, SEL_A,   SEL_A,   SEL_AR);
         6'd17: i = mk(OP_DIV, SEL_RD,  SEL_R,   SEL_A);
         6'd18: i = mk(OP_MUL, SEL_A,   SEL_PD,  SEL_A);
         6'd19: i = mk(OP_ADD, SEL_A,   SEL_A,   SEL_A);
         6'd20: i = mk(OP_NEG, SEL_A,   SEL_A,   SEL_AP);
         6'd21: i = mk(OP_MUL, SEL_RD,  SEL_RD,  SEL_A);
         6'd22: i = mk(OP_MUL, SEL_HF,  SEL_A,   SEL_A);
         6'd23: i = mk(OP_ADD, SEL_AR,  SEL_A,   SEL_AR);
         6'd24: i = mk(OP_MUL, SEL_R,   SEL_F,   SEL_A);
         6'd25: i = mk(OP_MUL, SEL_PD,  SEL_PD,  SEL_B);
         6'd26: i = mk(OP_MUL, SEL_A,   SEL_B,   SEL_A);
         6'd27: i = mk(OP_ADD, SEL_AR,  SEL_A,   SEL_AR);
         6'd28: i = mk(OP_MUL, SEL_TD,  SEL_DT,  SEL_A);
         6'd29: i = mk(OP_ADD, SEL_T,   SEL_A,   SEL_T);
         6'd30: i = mk(OP_MUL, SEL_RD,  SEL_DT,  SEL_A);
         6'd31: i = mk(OP_ADD, SEL_R,   SEL_A,   SEL_R);
         6'd32: i = mk(OP_MUL, SEL_PD,  SEL_DT,  SEL_A);
         6'd33: i = mk(OP_ADD, SEL_P,   SEL_A,   SEL_P);
         6'd34: i = mk(OP_MUL, SEL_AT,  SEL_DT,  SEL_A);
         6'd35: i = mk(OP_ADD, SEL_TD,  SEL_A,   SEL_TD);
         6'd36: i = mk(OP_MUL, SEL_AR,  SEL_DT,  SEL_A);
         6'd37: i = mk(OP_ADD, SEL_RD,  SEL_A,   SEL_RD);
         6'd38: i = mk(OP_MUL, SEL_AP,  SEL_DT,  SEL_A);
         6'd39: i = mk(OP_ADD, SEL_PD,  SEL_A,   SEL_PD);
         default: i = mk(OP_ADD, SEL_A, SEL_A, SEL_A);
      endcase
      return i;
   endfunction

endpackage
`default_nettype wire

### rtl/schwarzschild_orbit_euler_step.sv
// Top level of the Schwarzschild orbit Euler integrator.
// Uses sose_pkg, sose_ctrl, sose_dpath.
//
// One word at a time. A load word (mode 1) writes the state registers
// on acceptance; a load word or a zero-radius step then goes to the
// done state, where the result is captured and rsp_valid registered once
// no earlier result is waiting. A step word runs a 40-operation program
// on one shared saturating Q32.32 unit: four divides (one quotient bit a
// cycle), 20 multiplies (four 32x32 partial products each), and adds and
// negates. A zero metric factor faults after the first seven operations.
// The result word sits in an output register until taken; the next word
// may be accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module schwarzschild_orbit_euler_step
   import sose_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_mode,
   input  wire logic [63:0] req_load_time,
   input  wire logic [63:0] req_load_radius,
   input  wire logic [63:0] req_load_angle,
   input  wire logic [63:0] req_load_time_rate,
   input  wire logic [63:0] req_load_radius_rate,
   input  wire logic [63:0] req_load_angle_rate,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_fault,
   output logic [63:0]      rsp_out_time,
   output logic [63:0]      rsp_out_radius,
   output logic [63:0]      rsp_out_angle,
   output logic [63:0]      rsp_out_time_rate,
   output logic [63:0]      rsp_out_radius_rate,
   output logic [63:0]      rsp_out_angle_rate,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   sose_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_fault (rsp_fault),
      .cmd       (cmd),
      .stat      (stat)
   );

   sose_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .ld_t      (req_load_time),
      .ld_r      (req_load_radius),
      .ld_p      (req_load_angle),
      .ld_td     (req_load_time_rate),
      .ld_rd     (req_load_radius_rate),
      .ld_pd     (req_load_angle_rate),
      .o_t       (rsp_out_time),
      .o_r       (rsp_out_radius),
      .o_p       (rsp_out_angle),
      .o_td      (rsp_out_time_rate),
      .o_rd      (rsp_out_radius_rate),
      .o_pd      (rsp_out_angle_rate)
   );

endmodule
`default_nettype wire

### rtl/sose_arith.sv
// Shared saturating Q32.32 unit: multiply by 32x32 partial products,
// restoring divide one bit a cycle, add and negate. Uses sose_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sose_arith
   import sose_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  op_type            op,
   input  wire logic [W-1:0] a,
   input  wire logic [W-1:0] b,
   output logic              done,
   output logic [W-1:0]      result
);

   typedef enum logic [1:0] { A_IDLE, A_MUL, A_DIV, A_FIN } astate_type;

   astate_type      st_ff, st_in;
   op_type          op_ff;
   logic [W-1:0]    a_ff, b_ff, ma_ff, mb_ff;
   logic            neg_ff;
   logic [6:0]      cnt_ff;
   logic [127:0]    acc_ff;
   logic [95:0]     num_ff, quo_ff;
   logic [W-1:0]    rem_ff;

   logic [W-1:0]    ma, mb;
   logic [31:0]     pa, pb;
   logic [W-1:0]    prod;
   logic [127:0]    acc_in;
   logic [W:0]      rem_sh;
   logic            ge;

   function automatic logic [W-1:0] mag(logic [W-1:0] x);
      return x[W-1] ? (~x + 64'd1) : x;
   endfunction

   function automatic logic [W-1:0] pack(logic neg, logic [W-1:0] m);
      if (!neg) return m[W-1] ? 64'h7FFF_FFFF_FFFF_FFFF : m;
      if (m[W-1]) return 64'h8000_0000_0000_0000;
      return ~m + 64'd1;
   endfunction

   function automatic logic [W-1:0] sadd(logic [W-1:0] x, logic [W-1:0] y);
      logic [W:0] s;
      s = {x[W-1], x} + {y[W-1], y};
      if (s[W] != s[W-1]) return s[W] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      return s[W-1:0];
   endfunction

   assign ma = mag(a);
   assign mb = mag(b);

   assign pa = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign pb = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
   assign prod = {32'b0, pa} * {32'b0, pb};
   assign acc_in = acc_ff + ({64'b0, prod} << {2'({1'b0, cnt_ff[1]} + {1'b0, cnt_ff[0]}), 5'b0});

   assign rem_sh = {rem_ff, num_ff[95]};
   assign ge = rem_sh >= {1'b0, mb_ff};

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         A_IDLE: begin
            if (start) begin
               unique case (op)
                  OP_MUL:  st_in = A_MUL;
                  OP_DIV:  st_in = A_DIV;
                  default: st_in = A_FIN;
               endcase
            end
         end
         A_MUL:  if (cnt_ff == 7'd3) st_in = A_FIN;
         A_DIV:  if (cnt_ff == 7'd95) st_in = A_FIN;
         A_FIN:  st_in = A_IDLE;
         default: st_in = A_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= A_IDLE;
      end else begin
         st_ff <= st_in;
      end
      if (st_ff == A_IDLE && start) begin
         op_ff  <= op;
         a_ff   <= a;
         b_ff   <= b;
         ma_ff  <= ma;
         mb_ff  <= mb;
         neg_ff <= a[W-1] ^ b[W-1];
         cnt_ff <= '0;
         acc_ff <= '0;
         num_ff <= {ma, 32'b0};
         quo_ff <= '0;
         rem_ff <= '0;
      end else if (st_ff == A_MUL) begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_ff + 7'd1;
      end else if (st_ff == A_DIV) begin
         rem_ff <= ge ? 64'(rem_sh - {1'b0, mb_ff}) : rem_sh[W-1:0];
         quo_ff <= {quo_ff[94:0], ge};
         num_ff <= {num_ff[94:0], 1'b0};
         cnt_ff <= cnt_ff + 7'd1;
      end
   end

   always_comb begin
      unique case (op_ff)
         OP_MUL: result = pack(neg_ff, (acc_ff[127:96] != 32'b0) ? '1 : acc_ff[95:32]);
         OP_DIV: result = pack(neg_ff, (mb_ff == '0 || quo_ff[95:64] != 32'b0)
                                       ? '1 : quo_ff[63:0]);
         OP_ADD: result = sadd(a_ff, b_ff);
         OP_NEG: result = (a_ff == 64'h8000_0000_0000_0000) ? 64'h7FFF_FFFF_FFFF_FFFF
                                                            : ~a_ff + 64'd1;
         default: result = '0;
      endcase
   end

   assign done = (st_ff == A_FIN);

endmodule
`default_nettype wire

### rtl/sose_dpath.sv
// Datapath: state, configuration and scratch registers, operand selection,
// the shared arithmetic unit and the result word register. Uses sose_pkg, sose_arith.
`timescale 1ns / 1ps
`default_nettype none
module sose_dpath
   import sose_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [63:0]  csr_wdata,
   input  wire logic [W-1:0] ld_t, ld_r, ld_p, ld_td, ld_rd, ld_pd,
   output logic [W-1:0]      o_t, o_r, o_p, o_td, o_rd, o_pd
);

   logic [W-1:0] t_ff, r_ff, p_ff, td_ff, rd_ff, pd_ff;
   logic [W-1:0] gm_ff, icc_ff, dt_ff;
   logic [W-1:0] u_ff, g_ff, h_ff, s_ff, f_ff, hf_ff, at_ff, ar_ff, ap_ff, x_ff, y_ff;
   logic [W-1:0] ot_ff, or_ff, op_ff, otd_ff, ord_ff, opd_ff;
   logic [W-1:0] opa, opb, res;
   logic         done;

   function automatic logic [W-1:0] rd_sel(sel_type s,
      logic [W-1:0] t, logic [W-1:0] r, logic [W-1:0] p,
      logic [W-1:0] td, logic [W-1:0] rdt, logic [W-1:0] pd,
      logic [W-1:0] gm, logic [W-1:0] icc, logic [W-1:0] dt,
      logic [W-1:0] u, logic [W-1:0] g, logic [W-1:0] h, logic [W-1:0] sv,
      logic [W-1:0] f, logic [W-1:0] hf, logic [W-1:0] at, logic [W-1:0] ar,
      logic [W-1:0] ap, logic [W-1:0] x, logic [W-1:0] y);
      logic [W-1:0] v;
      unique case (s)
         SEL_T:   v = t;
         SEL_R:   v = r;
         SEL_P:   v = p;
         SEL_TD:  v = td;
         SEL_RD:  v = rdt;
         SEL_PD:  v = pd;
         SEL_GM:  v = gm;
         SEL_ICC: v = icc;
         SEL_DT:  v = dt;
         SEL_ONE: v = Q_ONE;
         SEL_U:   v = u;
         SEL_G:   v = g;
         SEL_H:   v = h;
         SEL_S:   v = sv;
         SEL_F:   v = f;
         SEL_HF:  v = hf;
         SEL_AT:  v = at;
         SEL_AR:  v = ar;
         SEL_AP:  v = ap;
         SEL_A:   v = x;
         SEL_B:   v = y;
         default: v = '0;
      endcase
      return v;
   endfunction

   assign opa = rd_sel(cmd.instr.src_a, t_ff, r_ff, p_ff, td_ff, rd_ff, pd_ff, gm_ff,
      icc_ff, dt_ff, u_ff, g_ff, h_ff, s_ff, f_ff, hf_ff, at_ff, ar_ff, ap_ff, x_ff, y_ff);
   assign opb = rd_sel(cmd.instr.src_b, t_ff, r_ff, p_ff, td_ff, rd_ff, pd_ff, gm_ff,
      icc_ff, dt_ff, u_ff, g_ff, h_ff, s_ff, f_ff, hf_ff, at_ff, ar_ff, ap_ff, x_ff, y_ff);

   sose_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start),
      .op     (cmd.instr.op),
      .a      (opa),
      .b      (opb),
      .done   (done),
      .result (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff   <= '0;
         r_ff   <= '0;
         p_ff   <= '0;
         td_ff  <= '0;
         rd_ff  <= '0;
         pd_ff  <= '0;
         gm_ff  <= 64'd4294967296;
         icc_ff <= 64'd4294967;
         dt_ff  <= 64'd4294967;
      end else begin
         if (csr_we) begin
            unique case (csr_idx_type'(csr_index))
               CSR_GM:  gm_ff  <= {1'b0, csr_wdata[62:0]};
               CSR_ICC: icc_ff <= {1'b0, csr_wdata[62:0]};
               CSR_DT:  dt_ff  <= {1'b0, csr_wdata[62:0]};
               default: ;
            endcase
         end
         if (cmd.load) begin
            t_ff  <= ld_t;
            r_ff  <= ld_r;
            p_ff  <= ld_p;
            td_ff <= ld_td;
            rd_ff <= ld_rd;
            pd_ff <= ld_pd;
         end else if (done) begin
            unique case (cmd.instr.dst)
               SEL_T:   t_ff  <= res;
               SEL_R:   r_ff  <= res;
               SEL_P:   p_ff  <= res;
               SEL_TD:  td_ff <= res;
               SEL_RD:  rd_ff <= res;
               SEL_PD:  pd_ff <= res;
               default: ;
            endcase
         end
      end
   end

   // scratch and result word registers, no reset
   always_ff @(posedge clock) begin
      if (done) begin
         unique case (cmd.instr.dst)
            SEL_U:   u_ff  <= res;
            SEL_G:   g_ff  <= res;
            SEL_H:   h_ff  <= res;
            SEL_S:   s_ff  <= res;
            SEL_F:   f_ff  <= res;
            SEL_HF:  hf_ff <= res;
            SEL_AT:  at_ff <= res;
            SEL_AR:  ar_ff <= res;
            SEL_AP:  ap_ff <= res;
            SEL_A:   x_ff  <= res;
            SEL_B:   y_ff  <= res;
            default: ;
         endcase
      end
      if (cmd.capture) begin
         ot_ff  <= t_ff;
         or_ff  <= r_ff;
         op_ff  <= p_ff;
         otd_ff <= td_ff;
         ord_ff <= rd_ff;
         opd_ff <= pd_ff;
      end
   end

   assign stat.done = done;
   assign stat.res_zero = (res == '0);
   assign stat.r_zero = (r_ff == '0);

   assign o_t  = ot_ff;
   assign o_r  = or_ff;
   assign o_p  = op_ff;
   assign o_td = otd_ff;
   assign o_rd = ord_ff;
   assign o_pd = opd_ff;

endmodule
`default_nettype wire

### rtl/sose_ctrl.sv
// Controller: accepts words, sequences the step program through the
// datapath and owns the result handshake. Uses sose_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sose_ctrl
   import sose_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   input  wire logic req_mode,
   output logic      req_ready,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic      rsp_fault,
   output cmd_type   cmd,
   input  stat_type  stat
);

   typedef enum logic [1:0] { S_IDLE, S_RUN, S_DONE } state_type;

   state_type       st_ff;
   logic [PC_W-1:0] pc_ff;
   logic            start_ff, fault_ff, rsp_valid_ff, rsp_fault_ff;
   logic            accept, capture;

   assign req_ready = (st_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign capture = (st_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         pc_ff        <= '0;
         start_ff     <= 1'b0;
         fault_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_fault_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready && !capture) rsp_valid_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: begin
               if (accept) begin
                  fault_ff <= 1'b0;
                  pc_ff    <= '0;
                  if (req_mode) begin
                     st_ff <= S_DONE;
                  end else if (stat.r_zero) begin
                     fault_ff <= 1'b1;
                     st_ff    <= S_DONE;
                  end else begin
                     start_ff <= 1'b1;
                     st_ff    <= S_RUN;
                  end
               end
            end
            S_RUN: begin
               if (stat.done) begin
                  if (pc_ff == PC_F_CHECK && stat.res_zero) begin
                     fault_ff <= 1'b1;
                     st_ff    <= S_DONE;
                  end else if (pc_ff == PC_LAST) begin
                     st_ff <= S_DONE;
                  end else begin
                     pc_ff    <= pc_ff + PC_W'(1);
                     start_ff <= 1'b1;
                  end
               end
            end
            S_DONE: begin
               if (capture) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_fault_ff <= fault_ff;
                  st_ff        <= S_IDLE;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign cmd.start   = start_ff;
   assign cmd.load    = accept && req_mode;
   assign cmd.capture = capture;
   assign cmd.instr   = program_step(pc_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_fault = rsp_fault_ff;

endmodule
`default_nettype wire

### rtl/sose_checker.sv
// Port-level checks for the orbit integrator and their bind.
// Uses schwarzschild_orbit_euler_step_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "schwarzschild_orbit_euler_step_defines.svh"
module sose_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [63:0] rsp_out_radius
);

   // one word in flight: no second accept right after the first
   `SOSE_ASSERT(a_one_inflight, clock, reset, (req_valid && req_ready) |=> !req_ready)
   // a reset leaves the block ready with nothing to deliver
   `SOSE_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (req_ready && !rsp_valid))
   // a result stays offered, unchanged, until taken
   `SOSE_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> rsp_valid)
   `SOSE_ASSERT(a_rsp_stable, clock, reset,
      (rsp_valid && !rsp_ready) |=> $stable(rsp_out_radius))

endmodule

bind schwarzschild_orbit_euler_step sose_checker u_sose_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_radius (rsp_out_radius)
);
`default_nettype wire
